// File: rtl/tsmc_pkg.sv
// Shared types, constants and helpers for the timestamp marker match cache.
// Used by tsmc_front, tsmc_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package tsmc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [30:0] WINDOW_RESET = 31'd2000;
  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [47:0]        address;
    logic [31:0]        rx_time;
    logic [31:0]        ident;
    logic [31:0]        session;
    logic signed [63:0] tx_time;
  } cmd_t;

  typedef struct packed {
    logic [47:0]        address;
    logic [31:0]        rx_time;
    logic [31:0]        ident;
    logic [31:0]        session;
    logic signed [63:0] tx_time;
  } entry_t;

  function automatic logic [31:0] wrapped_distance(input logic [31:0] a,
                                                   input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    if (d == HALF_RANGE) begin
      return DIST_MAX;
    end else if (d[31]) begin
      return 32'd0 - d;
    end else begin
      return d;
    end
  endfunction

endpackage

// File: rtl/tsmc_front.sv
// Front end: accepts command transactions, classifies them and queues them.
// Depends on tsmc_pkg.
`timescale 1ns / 1ps

module tsmc_front
  import tsmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [47:0]        source_address,
  input  logic [31:0]        rx_timestamp_us,
  input  logic [31:0]        sounding_ident,
  input  logic [31:0]        session_value,
  input  logic signed [63:0] tx_time_us,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  cmd_t                queue [QDEPTH];
  logic [QPTR_W-1:0]   head;
  logic [QPTR_W:0]     count;
  logic [QPTR_W:0]     count_next;
  logic [QPTR_W-1:0]   wr_idx;
  logic                push;
  logic                pop;
  cmd_t                incoming;

  assign busy = (count == (QPTR_W + 1)'(QDEPTH));
  assign push = start && !busy;
  assign cmd_valid = (count != '0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = queue[head];
  assign wr_idx = QPTR_W'(head + count[QPTR_W-1:0]);

  always_comb begin
    incoming.op = (opcode == 1'b1) ? OP_LOOKUP : OP_STORE;
    incoming.address = source_address;
    incoming.rx_time = rx_timestamp_us;
    incoming.ident = sounding_ident;
    incoming.session = session_value;
    incoming.tx_time = tx_time_us;
  end

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_idx] <= incoming;
    end
  end

endmodule

// File: rtl/tsmc_back.sv
// Back end: marker memory, ring write pointer and the nearest-timestamp scan.
// Depends on tsmc_pkg; takes commands from tsmc_front.
`timescale 1ns / 1ps

module tsmc_back
  import tsmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [30:0]        window,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               done,
  output logic               matched,
  output logic [31:0]        matched_ident,
  output logic [31:0]        matched_session,
  output logic signed [63:0] matched_tx_time_us,
  output logic signed [31:0] time_delta_us
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_RESULT
  } state_t;

  state_t             state;
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]   wp;
  logic [IDX_W-1:0]   wp_next;
  logic [IDX_W-1:0]   scan_idx;
  logic               mem_we;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic               rd_live;
  logic               rd_vld;
  logic [47:0]        q_addr;
  logic [31:0]        q_ts;
  logic [31:0]        cand_dist;
  logic               hit;
  logic               found;
  logic [31:0]        best_dist;
  logic [31:0]        best_ident;
  logic [31:0]        best_session;
  logic signed [63:0] best_tx;
  logic signed [31:0] best_delta;

  assign cmd_ready = (state == S_IDLE);
  assign mem_we = cmd_ready && cmd_valid && (cmd.op == OP_STORE);
  assign wp_next = (wp == IDX_W'(ENTRIES - 1)) ? '0 : wp + 1'b1;

  always_comb begin
    wr_entry.address = cmd.address;
    wr_entry.rx_time = cmd.rx_time;
    wr_entry.ident = cmd.ident;
    wr_entry.session = cmd.session;
    wr_entry.tx_time = cmd.tx_time;
  end

  always_comb begin
    cand_dist = wrapped_distance(rd_entry.rx_time, q_ts);
    hit = rd_live && rd_vld && (rd_entry.address == q_addr) &&
          (cand_dist <= {1'b0, window}) && (cand_dist < best_dist);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= wr_entry;
    end
    rd_entry <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp <= '0;
      entry_valid <= '0;
      rd_live <= 1'b0;
      found <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      rd_live <= 1'b0;
      if (hit) begin
        found <= 1'b1;
        best_dist <= cand_dist;
        best_ident <= rd_entry.ident;
        best_session <= rd_entry.session;
        best_tx <= rd_entry.tx_time;
        best_delta <= q_ts - rd_entry.rx_time;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_STORE) begin
              entry_valid[wp] <= 1'b1;
              wp <= wp_next;
            end else begin
              q_addr <= cmd.address;
              q_ts <= cmd.rx_time;
              scan_idx <= '0;
              best_dist <= DIST_MAX;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_live <= 1'b1;
          rd_vld <= entry_valid[scan_idx];
          if (scan_idx == IDX_W'(ENTRIES - 1)) begin
            state <= S_LAST;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_LAST: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          done <= 1'b1;
          matched <= found;
          matched_ident <= found ? best_ident : '0;
          matched_session <= found ? best_session : '0;
          matched_tx_time_us <= found ? best_tx : '0;
          time_delta_us <= found ? best_delta : '0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_RESULT)
    else $error("Result strobe without a finished scan.");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !matched) |-> (matched_ident == '0 && matched_session == '0 &&
                            matched_tx_time_us == '0 && time_delta_us == '0))
    else $error("Unmatched result carries nonzero fields.");

  a_best_in_window: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && found) |-> best_dist <= {1'b0, window})
    else $error("Best candidate lies outside the window.");

  a_store_only_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> $past(state) == S_IDLE && rd_live == 1'b0)
    else $error("Memory write during a scan.");
`endif

endmodule

// File: rtl/timestamp_marker_match_cache_core.sv
// Top level of the timestamp marker match cache: window register, front end
// and back end. Depends on tsmc_pkg, tsmc_front and tsmc_back.
`timescale 1ns / 1ps

// Usage:
// A command transaction is accepted at a rising edge where start is high and
// busy is low. opcode 0 stores a marker at the ring write pointer, opcode 1
// looks up the nearest marker with the same source address.
// Commands enter a two-deep queue, so busy rises only when both slots hold
// transactions the back end has not yet taken.
// A store produces no result; it is written to the marker memory in the same
// cycle it is dequeued. A lookup scans the marker memory one entry per cycle
// through its single read port and holds the back end until its result is
// out; the result appears on the result ports with done high for exactly
// one cycle. The back end takes one store per cycle while it is idle.
// The result cannot be stalled by the receiver: it must take it when done
// is high.
// window_we writes window_wdata into the match window register; write it
// only while no transaction is outstanding.
// Reset (rst, synchronous) empties the queue, clears all valid marks and the
// write pointer, and loads the match window with 2000 us.

module timestamp_marker_match_cache_core
  import tsmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [47:0]        source_address,
  input  logic [31:0]        rx_timestamp_us,
  input  logic [31:0]        sounding_ident,
  input  logic [31:0]        session_value,
  input  logic signed [63:0] tx_time_us,
  input  logic               window_we,
  input  logic [30:0]        window_wdata,
  output logic               done,
  output logic               matched,
  output logic [31:0]        matched_ident,
  output logic [31:0]        matched_session,
  output logic signed [63:0] matched_tx_time_us,
  output logic signed [31:0] time_delta_us
);

  logic [30:0] window;
  logic        cmd_valid;
  logic        cmd_ready;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (window_we) begin
      window <= window_wdata;
    end
  end

  tsmc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .source_address  (source_address),
    .rx_timestamp_us (rx_timestamp_us),
    .sounding_ident  (sounding_ident),
    .session_value   (session_value),
    .tx_time_us      (tx_time_us),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd)
  );

  tsmc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .window             (window),
    .cmd_valid          (cmd_valid),
    .cmd_ready          (cmd_ready),
    .cmd                (cmd),
    .done               (done),
    .matched            (matched),
    .matched_ident      (matched_ident),
    .matched_session    (matched_session),
    .matched_tx_time_us (matched_tx_time_us),
    .time_delta_us      (time_delta_us)
  );

endmodule
